/* design/bsi_pkg.sv */
// shared constants, item codes and queue word type for the setpoint interpolator
package bsi_pkg;

  localparam int PROFILE_SLOTS    = 4;
  localparam int POINTS_PER_CURVE = 16;

  localparam int CMD_W  = 2;
  localparam int T_W    = 24;
  localparam int VAL_W  = 16;
  localparam int IDX_FIELD_W   = 4;
  localparam int COUNT_FIELD_W = 5;

  localparam int CURVES    = PROFILE_SLOTS * 2;
  localparam int PROF_W    = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
  localparam int CURVE_W   = PROF_W + 1;
  localparam int PT_W      = $clog2(POINTS_PER_CURVE);
  localparam int CNT_W     = $clog2(POINTS_PER_CURVE + 1);
  localparam int ADDR_W    = CURVE_W + PT_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int PRODUCT_W = T_W + VAL_W;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_POINT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEADER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    K_POINT,
    K_HEADER,
    K_QUERY,
    K_QUERY_OFF
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CURVE_W-1:0] curve;
    logic [PT_W-1:0]    idx;
    logic [T_W-1:0]     tval;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic               pvalid;
  } item_t;

endpackage

/* design/bsi_front.sv */
// front end: accepts input words, classifies them and queues them for the back end
module bsi_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsi_pkg::CMD_W-1:0]         command,
  input  logic [1:0]                        profile,
  input  logic                              channel,
  input  logic [bsi_pkg::IDX_FIELD_W-1:0]   point_index,
  input  logic [bsi_pkg::T_W-1:0]           point_time,
  input  logic [bsi_pkg::VAL_W-1:0]         load_value,
  input  logic [bsi_pkg::COUNT_FIELD_W-1:0] point_count,
  input  logic                              profile_valid,
  input  logic [bsi_pkg::T_W-1:0]           elapsed,
  output logic                              q_valid,
  output bsi_pkg::item_t                    q_item,
  input  logic                              q_pop
);

  bsi_pkg::item_t                    slots [bsi_pkg::QDEPTH];
  logic [bsi_pkg::QPTR_W-1:0]        wr_ptr;
  logic [bsi_pkg::QPTR_W-1:0]        rd_ptr;
  logic [bsi_pkg::QCNT_W-1:0]        count;
  bsi_pkg::item_t                    item;
  logic                              keep;
  logic                              push;
  logic                              in_range;
  logic                              idx_ok;

  assign in_range = int'(profile) < bsi_pkg::PROFILE_SLOTS;
  assign idx_ok   = int'(point_index) < bsi_pkg::POINTS_PER_CURVE;

  always_comb begin
    item.curve  = {bsi_pkg::PROF_W'(profile), channel};
    item.idx    = bsi_pkg::PT_W'(point_index);
    item.tval   = (command == bsi_pkg::CMD_QUERY) ? elapsed : point_time;
    item.value  = load_value;
    item.pvalid = profile_valid;
    if (int'(point_count) > bsi_pkg::POINTS_PER_CURVE) begin
      item.count = bsi_pkg::CNT_W'(bsi_pkg::POINTS_PER_CURVE);
    end else begin
      item.count = bsi_pkg::CNT_W'(point_count);
    end
    item.kind = bsi_pkg::K_QUERY_OFF;
    keep      = 1'b0;
    unique case (command)
      bsi_pkg::CMD_POINT: begin
        item.kind = bsi_pkg::K_POINT;
        keep      = in_range && idx_ok;
      end
      bsi_pkg::CMD_HEADER: begin
        item.kind = bsi_pkg::K_HEADER;
        keep      = in_range;
      end
      bsi_pkg::CMD_QUERY: begin
        item.kind = in_range ? bsi_pkg::K_QUERY : bsi_pkg::K_QUERY_OFF;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (count != bsi_pkg::QCNT_W'(bsi_pkg::QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    count <= bsi_pkg::QCNT_W'(bsi_pkg::QDEPTH))
    else $error("queue overfilled");

endmodule

/* design/bsi_div.sv */
// restoring divider, one quotient bit per cycle, quotient known to fit the value width
module bsi_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bsi_pkg::PRODUCT_W-1:0] dividend,
  input  logic [bsi_pkg::T_W-1:0]       divisor,
  output logic                          done,
  output logic [bsi_pkg::VAL_W-1:0]     quotient
);

  logic                            busy;
  logic [bsi_pkg::DIV_CNT_W-1:0]   cnt;
  logic [bsi_pkg::T_W-1:0]         rem;
  logic [bsi_pkg::VAL_W-1:0]       low;
  logic [bsi_pkg::T_W:0]           trial;
  logic                            qbit;

  assign trial    = {rem, low[bsi_pkg::VAL_W-1]};
  assign qbit     = trial >= {1'b0, divisor};
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[bsi_pkg::PRODUCT_W-1:bsi_pkg::VAL_W];
      low <= dividend[bsi_pkg::VAL_W-1:0];
    end else if (busy) begin
      rem <= qbit ? bsi_pkg::T_W'(trial - {1'b0, divisor}) : bsi_pkg::T_W'(trial);
      low <= {low[bsi_pkg::VAL_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == bsi_pkg::DIV_CNT_W'(bsi_pkg::VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/bsi_back.sv */
// back end: table writes, breakpoint walk, interpolation and the output register
module bsi_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  bsi_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bsi_pkg::VAL_W-1:0] setpoint
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEG,
    S_MUL,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  state_t                            state;
  logic [bsi_pkg::T_W+bsi_pkg::VAL_W-1:0] mem [bsi_pkg::MEM_DEPTH];
  logic [bsi_pkg::T_W+bsi_pkg::VAL_W-1:0] rdata;
  logic [bsi_pkg::ADDR_W-1:0]        rd_addr;
  logic                              mem_we;

  logic [bsi_pkg::CNT_W-1:0]         counts    [bsi_pkg::CURVES];
  logic [bsi_pkg::VAL_W-1:0]         fallbacks [bsi_pkg::CURVES];
  logic                              pv_bits   [bsi_pkg::PROFILE_SLOTS];

  logic [bsi_pkg::CURVE_W-1:0]       curve;
  logic [bsi_pkg::T_W-1:0]           e;
  logic [bsi_pkg::CNT_W-1:0]         n;
  logic [bsi_pkg::PT_W-1:0]          j;
  logic [bsi_pkg::T_W-1:0]           t_prev;
  logic [bsi_pkg::VAL_W-1:0]         v_prev;
  logic [bsi_pkg::T_W-1:0]           dte;
  logic [bsi_pkg::T_W-1:0]           dt;
  logic [bsi_pkg::VAL_W-1:0]         dv_mag;
  logic                              dv_neg;
  logic [bsi_pkg::PRODUCT_W-1:0]     product;
  logic [bsi_pkg::VAL_W-1:0]         result;

  logic [bsi_pkg::T_W-1:0]           rd_t;
  logic [bsi_pkg::VAL_W-1:0]         rd_v;
  logic [bsi_pkg::PROF_W-1:0]        q_prof;
  logic                              div_start;
  logic                              div_done;
  logic [bsi_pkg::VAL_W-1:0]         quotient;
  logic                              out_free;

  assign rd_t      = rdata[bsi_pkg::T_W+bsi_pkg::VAL_W-1:bsi_pkg::VAL_W];
  assign rd_v      = rdata[bsi_pkg::VAL_W-1:0];
  assign q_prof    = q_item.curve[bsi_pkg::CURVE_W-1:1];
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mem_we    = q_pop && (q_item.kind == bsi_pkg::K_POINT);
  assign div_start = (state == S_START);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = {q_item.curve, bsi_pkg::PT_W'(0)};
      S_FIRST: rd_addr = {curve, bsi_pkg::PT_W'(n - 1'b1)};
      S_LAST:  rd_addr = {curve, bsi_pkg::PT_W'(1)};
      S_SEG:   rd_addr = {curve, j + 1'b1};
      default: rd_addr = {curve, j};
    endcase
  end

  // breakpoint store, time in the upper bits
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{q_item.curve, q_item.idx}] <= {q_item.tval, q_item.value};
    end
    rdata <= mem[rd_addr];
  end

  bsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (dt),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < bsi_pkg::CURVES; i++) begin
        counts[i]    <= '0;
        fallbacks[i] <= '0;
      end
      for (int i = 0; i < bsi_pkg::PROFILE_SLOTS; i++) begin
        pv_bits[i] <= 1'b0;
      end
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            curve <= q_item.curve;
            e     <= q_item.tval;
            unique case (q_item.kind)
              bsi_pkg::K_POINT: begin
              end
              bsi_pkg::K_HEADER: begin
                counts[q_item.curve]    <= q_item.count;
                fallbacks[q_item.curve] <= q_item.value;
                pv_bits[q_prof]         <= q_item.pvalid;
              end
              bsi_pkg::K_QUERY: begin
                n <= counts[q_item.curve];
                if (!pv_bits[q_prof]) begin
                  result <= '0;
                  state  <= S_OUT;
                end else if (counts[q_item.curve] == '0) begin
                  result <= fallbacks[q_item.curve];
                  state  <= S_OUT;
                end else begin
                  state <= S_FIRST;
                end
              end
              bsi_pkg::K_QUERY_OFF: begin
                result <= '0;
                state  <= S_OUT;
              end
              default: begin
              end
            endcase
          end
        end
        S_FIRST: begin
          t_prev <= rd_t;
          v_prev <= rd_v;
          state  <= S_LAST;
        end
        S_LAST: begin
          if (e <= t_prev) begin
            result <= v_prev;
            state  <= S_OUT;
          end else if (e >= rd_t) begin
            result <= rd_v;
            state  <= S_OUT;
          end else begin
            j     <= bsi_pkg::PT_W'(1);
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (e >= t_prev && e <= rd_t) begin
            if (e <= t_prev) begin
              result <= v_prev;
              state  <= S_OUT;
            end else if (e >= rd_t) begin
              result <= rd_v;
              state  <= S_OUT;
            end else begin
              dte    <= e - t_prev;
              dt     <= rd_t - t_prev;
              dv_neg <= rd_v < v_prev;
              dv_mag <= (rd_v < v_prev) ? (v_prev - rd_v) : (rd_v - v_prev);
              state  <= S_MUL;
            end
          end else if (bsi_pkg::CNT_W'(j) + bsi_pkg::CNT_W'(1) == n) begin
            result <= fallbacks[curve];
            state  <= S_OUT;
          end else begin
            t_prev <= rd_t;
            v_prev <= rd_v;
            j      <= j + 1'b1;
          end
        end
        S_MUL: begin
          product <= dte * dv_mag;
          state   <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            result <= dv_neg ? (v_prev - quotient) : (v_prev + quotient);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            setpoint <= result;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == S_SEG |-> bsi_pkg::CNT_W'(j) < n)
    else $error("segment walk past last point");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide wait");

endmodule

/* design/breakpoint_setpoint_interpolator.sv */
// top level of the breakpoint setpoint interpolator
// write words: update the table when the back end takes them from the queue, no result word
// query: one result word, from a walk over k segments (k = 1 to 15) and a divide;
//   no walk when the profile is off or the curve is empty, or when the time clamps to an end;
//   no divide when it lands on a breakpoint; one point read a cycle, one quotient bit a cycle
// one query at a time in the back end; a two-word queue keeps the input
//   taking words. synchronous active-high reset clears headers, valid bits and control
module breakpoint_setpoint_interpolator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsi_pkg::CMD_W-1:0]         command,
  input  logic [1:0]                        profile,
  input  logic                              channel,
  input  logic [bsi_pkg::IDX_FIELD_W-1:0]   point_index,
  input  logic [bsi_pkg::T_W-1:0]           point_time,
  input  logic [bsi_pkg::VAL_W-1:0]         load_value,
  input  logic [bsi_pkg::COUNT_FIELD_W-1:0] point_count,
  input  logic                              profile_valid,
  input  logic [bsi_pkg::T_W-1:0]           elapsed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bsi_pkg::VAL_W-1:0]         setpoint
);

  logic           q_valid;
  bsi_pkg::item_t q_item;
  logic           q_pop;

  bsi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .profile       (profile),
    .channel       (channel),
    .point_index   (point_index),
    .point_time    (point_time),
    .load_value    (load_value),
    .point_count   (point_count),
    .profile_valid (profile_valid),
    .elapsed       (elapsed),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  bsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .setpoint  (setpoint)
  );

endmodule
